[rtl/tfsa_pkg.sv]
// ----------------------------------------------------------------------------
// tfsa_pkg: shared definitions for the tile fetch / scroll address block
// Field widths, address constants, line kinds and the pending read codes.
// ----------------------------------------------------------------------------
`default_nettype none

package tfsa_pkg;

   localparam int KindWidth    = 2;
   localparam int DotWidth     = 9;
   localparam int LineWidth    = 9;
   localparam int VaddrWidth   = 15;
   localparam int DataWidth    = 8;
   localparam int FaddrWidth   = 14;
   localparam int PixelsWidth  = 16;
   localparam int PaletteWidth = 2;
   localparam int MaskWidth    = 8;
   localparam int CsrIdxWidth  = 1;
   localparam int CsrDataWidth = 1;

   // configuration register indexes
   localparam logic [CsrIdxWidth-1:0] CSR_RENDER_ENABLE   = 1'd0;
   localparam logic [CsrIdxWidth-1:0] CSR_BG_PATTERN_HIGH = 1'd1;

   // line kinds
   localparam logic [KindWidth-1:0] KIND_VISIBLE    = 2'd0;
   localparam logic [KindWidth-1:0] KIND_PRE_RENDER = 2'd1;

   // memory map and scroll field masks
   localparam logic [FaddrWidth-1:0] NT_BASE    = 14'h2000;
   localparam logic [FaddrWidth-1:0] AT_BASE    = 14'h23C0;
   localparam logic [VaddrWidth-1:0] HORZ_MASK  = 15'h041F;
   localparam logic [VaddrWidth-1:0] VERT_MASK  = 15'h7BE0;
   localparam logic [4:0]            COARSE_MAX = 5'd31;
   localparam logic [4:0]            COARSE_Y_WRAP = 5'd29;
   localparam logic [2:0]            FINE_Y_MAX = 3'd7;

   // dot windows
   localparam logic [DotWidth-1:0] DOT_FIRST      = 9'd1;
   localparam logic [DotWidth-1:0] DOT_LAST       = 9'd256;
   localparam logic [DotWidth-1:0] DOT_HCOPY      = 9'd257;
   localparam logic [DotWidth-1:0] DOT_VCOPY_LO   = 9'd280;
   localparam logic [DotWidth-1:0] DOT_VCOPY_HI   = 9'd304;
   localparam logic [DotWidth-1:0] DOT_PREF_LO    = 9'd321;
   localparam logic [DotWidth-1:0] DOT_PREF_HI    = 9'd336;
   localparam logic [DotWidth-1:0] DOT_PRE_END    = 9'd340;
   localparam logic [DotWidth:0]   PREF_COL_OFS   = 10'd328;
   localparam logic [DotWidth:0]   COL_OFS        = 10'd8;
   localparam logic [DotWidth:0]   FRAME_WIDTH    = 10'd256;
   localparam logic [LineWidth:0]  FRAME_HEIGHT   = 10'd240;

   // phase of dot within an 8-dot fetch group
   localparam logic [2:0] PHASE_EMIT = 3'd0;
   localparam logic [2:0] PHASE_NT   = 3'd1;
   localparam logic [2:0] PHASE_AT   = 3'd3;
   localparam logic [2:0] PHASE_LO   = 3'd5;
   localparam logic [2:0] PHASE_HI   = 3'd7;

   typedef enum logic [2:0] {
      PEND_NONE,
      PEND_NT,
      PEND_AT,
      PEND_LO,
      PEND_HI
   } pend_type;

   typedef struct packed {
      logic [VaddrWidth-1:0]   vram_addr;
      logic [FaddrWidth-1:0]   fetch_address;
      logic                    fetch_valid;
      logic                    tile_valid;
      logic [PixelsWidth-1:0]  tile_pixels;
      logic [PaletteWidth-1:0] palette_select;
      logic [LineWidth-1:0]    pixel_row;
      logic [DotWidth-1:0]     column_start;
      logic [MaskWidth-1:0]    pixel_mask;
   } result_type;

endpackage

`default_nettype wire

[rtl/tfsa_if.sv]
// ----------------------------------------------------------------------------
// tfsa channel interfaces
// Valid/ready channels for dot requests and fetch results.
// ----------------------------------------------------------------------------
`default_nettype none

interface tfsa_req_if;
   logic                               valid;
   logic                               ready;
   logic [tfsa_pkg::KindWidth-1:0]     line_kind;
   logic [tfsa_pkg::DotWidth-1:0]      dot;
   logic [tfsa_pkg::LineWidth-1:0]     scanline;
   logic [tfsa_pkg::VaddrWidth-1:0]    t_value;
   logic [tfsa_pkg::DataWidth-1:0]     read_data;

   modport source (output valid, line_kind, dot, scanline, t_value, read_data,
                   input ready);
   modport sink   (input valid, line_kind, dot, scanline, t_value, read_data,
                   output ready);
endinterface

interface tfsa_rsp_if;
   logic                                valid;
   logic                                ready;
   logic [tfsa_pkg::VaddrWidth-1:0]     vram_addr;
   logic [tfsa_pkg::FaddrWidth-1:0]     fetch_address;
   logic                                fetch_valid;
   logic                                tile_valid;
   logic [tfsa_pkg::PixelsWidth-1:0]    tile_pixels;
   logic [tfsa_pkg::PaletteWidth-1:0]   palette_select;
   logic [tfsa_pkg::LineWidth-1:0]      pixel_row;
   logic [tfsa_pkg::DotWidth-1:0]       column_start;
   logic [tfsa_pkg::MaskWidth-1:0]      pixel_mask;

   modport source (output valid, vram_addr, fetch_address, fetch_valid, tile_valid,
                   tile_pixels, palette_select, pixel_row, column_start, pixel_mask,
                   input ready);
   modport sink   (input valid, vram_addr, fetch_address, fetch_valid, tile_valid,
                   tile_pixels, palette_select, pixel_row, column_start, pixel_mask,
                   output ready);
endinterface

`default_nettype wire

[rtl/tile_fetch_scroll_address.sv]
// ----------------------------------------------------------------------------
// tile_fetch_scroll_address
// Background tile fetch sequencer and scroll address (v) keeper, one dot
// per request.
// ----------------------------------------------------------------------------
// Usage:
//   req_channel carries one dot per request: line kind, dot, scanline, the
//   temporary address t and the memory byte answering the previous fetch.
//   rsp_channel returns one result per request: v after the dot, the fetch
//   address issued on it and, on every eighth dot, eight 2-bit pixels with
//   palette, row, column and frame clip mask.
//   csr_* writes render_enable (index 0) and bg_pattern_high (index 1);
//   write only while no request is in flight.
//   The result is registered and appears in the cycle after its request
//   is taken. One request is taken per cycle; the result register decides
//   the rate: a request is taken when the register is empty or its result
//   is taken in the same cycle. When the receiver stalls, the result is
//   held and requests stop once the register is full; nothing is lost.
//   Reset (synchronous, active high) clears v, the latched tile index,
//   attribute and low pattern byte, the pending read and both config bits.
// ----------------------------------------------------------------------------
`default_nettype none

module tile_fetch_scroll_address (
   input  wire logic                                clock,
   input  wire logic                                reset,
   tfsa_req_if.sink                                 req_channel,
   tfsa_rsp_if.source                               rsp_channel,
   input  wire logic                                csr_write_enable,
   input  wire logic [tfsa_pkg::CsrIdxWidth-1:0]    csr_index,
   input  wire logic [tfsa_pkg::CsrDataWidth-1:0]   csr_write_data
);

   logic                                render_enable_ff;
   logic                                bg_pattern_high_ff;
   logic [tfsa_pkg::VaddrWidth-1:0]     vaddr_ff, vaddr_in;
   logic [tfsa_pkg::DataWidth-1:0]      tile_index_ff, tile_index_in;
   logic [1:0]                          quadrant_ff, quadrant_in;
   logic [tfsa_pkg::PaletteWidth-1:0]   palette_ff, palette_in;
   logic [tfsa_pkg::DataWidth-1:0]      pattern_low_ff, pattern_low_in;
   tfsa_pkg::pend_type                  pending_ff, pending_in;
   logic                                rsp_valid_ff, rsp_valid_in;
   tfsa_pkg::result_type                result_ff, result_in;

   logic                                accept;
   logic [tfsa_pkg::KindWidth-1:0]      kind;
   logic [tfsa_pkg::DotWidth-1:0]       dot;
   logic [tfsa_pkg::DataWidth-1:0]      rd;
   logic                                in_pipe;
   logic                                pre;
   logic [2:0]                          prow;
   logic [tfsa_pkg::LineWidth:0]        row_wide;
   logic [tfsa_pkg::DotWidth:0]         col_wide;
   logic [tfsa_pkg::VaddrWidth-1:0]     v_x;
   logic [4:0]                          next_tile_row;

   assign kind   = req_channel.line_kind;
   assign dot    = req_channel.dot;
   assign rd     = req_channel.read_data;
   assign accept = req_channel.valid && req_channel.ready;
   assign req_channel.ready = !rsp_valid_ff || rsp_channel.ready;

   always_comb begin
      // byte answering the previous dot's read lands first
      tile_index_in  = tile_index_ff;
      palette_in     = palette_ff;
      pattern_low_in = pattern_low_ff;
      case (pending_ff)
         tfsa_pkg::PEND_NT: tile_index_in = rd;
         tfsa_pkg::PEND_AT: begin
            case (quadrant_ff)
               2'd0:    palette_in = rd[1:0];
               2'd1:    palette_in = rd[3:2];
               2'd2:    palette_in = rd[5:4];
               default: palette_in = rd[7:6];
            endcase
         end
         tfsa_pkg::PEND_LO: pattern_low_in = rd;
         default: ;
      endcase

      pending_in  = tfsa_pkg::PEND_NONE;
      quadrant_in = quadrant_ff;
      vaddr_in    = vaddr_ff;
      result_in   = '0;

      in_pipe = ((kind == tfsa_pkg::KIND_VISIBLE) &&
                 (((dot >= tfsa_pkg::DOT_FIRST) && (dot <= tfsa_pkg::DOT_LAST)) ||
                  ((dot >= tfsa_pkg::DOT_PREF_LO) && (dot <= tfsa_pkg::DOT_PREF_HI)))) ||
                ((kind == tfsa_pkg::KIND_PRE_RENDER) && render_enable_ff &&
                 (dot >= tfsa_pkg::DOT_PREF_LO) && (dot <= tfsa_pkg::DOT_PRE_END));
      pre      = (dot >= tfsa_pkg::DOT_PREF_LO) && (dot <= tfsa_pkg::DOT_PREF_HI);
      row_wide = {1'b0, req_channel.scanline} + {{tfsa_pkg::LineWidth{1'b0}}, pre};
      prow     = row_wide[2:0];
      col_wide = pre ? ({1'b0, dot} - tfsa_pkg::PREF_COL_OFS)
                     : ({1'b0, dot} + tfsa_pkg::COL_OFS);

      // coarse x step with horizontal nametable toggle
      if (vaddr_ff[4:0] == tfsa_pkg::COARSE_MAX) begin
         v_x = {vaddr_ff[14:11], ~vaddr_ff[10], vaddr_ff[9:5], 5'd0};
      end else begin
         v_x = vaddr_ff + 15'd1;
      end
      case (v_x[9:5])
         tfsa_pkg::COARSE_Y_WRAP: next_tile_row = 5'd0;
         tfsa_pkg::COARSE_MAX:    next_tile_row = 5'd0;
         default:                 next_tile_row = v_x[9:5] + 5'd1;
      endcase

      if ((kind == tfsa_pkg::KIND_VISIBLE) && (dot == tfsa_pkg::DOT_HCOPY)) begin
         vaddr_in = (vaddr_ff & tfsa_pkg::VERT_MASK) |
                    (req_channel.t_value & tfsa_pkg::HORZ_MASK);
      end
      if ((kind == tfsa_pkg::KIND_PRE_RENDER) && (dot >= tfsa_pkg::DOT_VCOPY_LO) &&
          (dot <= tfsa_pkg::DOT_VCOPY_HI)) begin
         vaddr_in = (vaddr_ff & tfsa_pkg::HORZ_MASK) |
                    (req_channel.t_value & tfsa_pkg::VERT_MASK);
      end

      if (in_pipe) begin
         case (dot[2:0])
            tfsa_pkg::PHASE_NT: begin
               result_in.fetch_address = tfsa_pkg::NT_BASE | {2'b00, vaddr_ff[11:0]};
               result_in.fetch_valid   = 1'b1;
               pending_in              = tfsa_pkg::PEND_NT;
            end
            tfsa_pkg::PHASE_AT: begin
               result_in.fetch_address = tfsa_pkg::AT_BASE |
                  {2'b00, vaddr_ff[11:10], 4'd0, vaddr_ff[9:7], vaddr_ff[4:2]};
               result_in.fetch_valid   = 1'b1;
               quadrant_in             = {vaddr_ff[6], vaddr_ff[1]};
               pending_in              = tfsa_pkg::PEND_AT;
            end
            tfsa_pkg::PHASE_LO: begin
               result_in.fetch_address = {1'b0, bg_pattern_high_ff, tile_index_in,
                                          1'b0, prow};
               result_in.fetch_valid   = 1'b1;
               pending_in              = tfsa_pkg::PEND_LO;
            end
            tfsa_pkg::PHASE_HI: begin
               result_in.fetch_address = {1'b0, bg_pattern_high_ff, tile_index_in,
                                          1'b1, prow};
               result_in.fetch_valid   = 1'b1;
               pending_in              = tfsa_pkg::PEND_HI;
            end
            tfsa_pkg::PHASE_EMIT: begin
               if (dot == tfsa_pkg::DOT_LAST) begin
                  // fine y step, carrying into coarse y
                  if (v_x[14:12] != tfsa_pkg::FINE_Y_MAX) begin
                     vaddr_in = {v_x[14:12] + 3'd1, v_x[11:0]};
                  end else begin
                     vaddr_in = {3'd0,
                                 v_x[11] ^ (v_x[9:5] == tfsa_pkg::COARSE_Y_WRAP),
                                 v_x[10], next_tile_row, v_x[4:0]};
                  end
               end else begin
                  vaddr_in = v_x;
               end
               result_in.tile_valid     = 1'b1;
               result_in.palette_select = palette_in;
               result_in.pixel_row      = row_wide[tfsa_pkg::LineWidth-1:0];
               result_in.column_start   = col_wide[tfsa_pkg::DotWidth-1:0];
               for (int i = 0; i < tfsa_pkg::MaskWidth; i++) begin
                  result_in.tile_pixels[2*i+1] = rd[i];
                  result_in.tile_pixels[2*i]   = pattern_low_in[i];
                  result_in.pixel_mask[i] =
                     ((col_wide + 10'(i)) < tfsa_pkg::FRAME_WIDTH) &&
                     (row_wide < tfsa_pkg::FRAME_HEIGHT);
               end
            end
            default: ;
         endcase
      end
      result_in.vram_addr = vaddr_in;

      rsp_valid_in = accept || (rsp_valid_ff && !rsp_channel.ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         render_enable_ff   <= 1'b0;
         bg_pattern_high_ff <= 1'b0;
         vaddr_ff           <= '0;
         tile_index_ff      <= '0;
         quadrant_ff        <= '0;
         palette_ff         <= '0;
         pattern_low_ff     <= '0;
         pending_ff         <= tfsa_pkg::PEND_NONE;
         rsp_valid_ff       <= 1'b0;
      end else begin
         if (csr_write_enable) begin
            case (csr_index)
               tfsa_pkg::CSR_RENDER_ENABLE:   render_enable_ff   <= csr_write_data[0];
               tfsa_pkg::CSR_BG_PATTERN_HIGH: bg_pattern_high_ff <= csr_write_data[0];
               default: ;
            endcase
         end
         if (accept) begin
            vaddr_ff       <= vaddr_in;
            tile_index_ff  <= tile_index_in;
            quadrant_ff    <= quadrant_in;
            palette_ff     <= palette_in;
            pattern_low_ff <= pattern_low_in;
            pending_ff     <= pending_in;
         end
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         result_ff <= result_in;
      end
   end

   assign rsp_channel.valid          = rsp_valid_ff;
   assign rsp_channel.vram_addr      = result_ff.vram_addr;
   assign rsp_channel.fetch_address  = result_ff.fetch_address;
   assign rsp_channel.fetch_valid    = result_ff.fetch_valid;
   assign rsp_channel.tile_valid     = result_ff.tile_valid;
   assign rsp_channel.tile_pixels    = result_ff.tile_pixels;
   assign rsp_channel.palette_select = result_ff.palette_select;
   assign rsp_channel.pixel_row      = result_ff.pixel_row;
   assign rsp_channel.column_start   = result_ff.column_start;
   assign rsp_channel.pixel_mask     = result_ff.pixel_mask;

   // idle line kinds leave v alone
   a_idle_kind_keeps_v: assert property (@(posedge clock) disable iff (reset)
      accept && (kind != tfsa_pkg::KIND_VISIBLE) && (kind != tfsa_pkg::KIND_PRE_RENDER)
      |=> vaddr_ff == $past(vaddr_ff))
      else $error("v changed on an idle line kind");

   // a dot either fetches or emits pixels, never both
   a_fetch_or_emit: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(result_ff.fetch_valid && result_ff.tile_valid))
      else $error("fetch and emit on the same dot");

   // rows below the frame are fully clipped
   a_row_clip: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && result_ff.tile_valid && (result_ff.pixel_row >= 9'd240)
      |-> result_ff.pixel_mask == '0)
      else $error("clip mask set below the frame");

   // non-emitting dots carry zeroed pixel fields
   a_quiet_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !result_ff.tile_valid
      |-> (result_ff.tile_pixels == '0) && (result_ff.pixel_mask == '0) &&
          (result_ff.column_start == '0))
      else $error("pixel fields set without a tile");

   // a read is pending only right after a fetch was issued
   a_pending_follows_fetch: assert property (@(posedge clock) disable iff (reset)
      accept && !pending_in[0] && !pending_in[1] && !pending_in[2]
      |=> pending_ff == tfsa_pkg::PEND_NONE)
      else $error("read pending without a fetch");

endmodule

`default_nettype wire
